/* rtl/puq_pkg.sv */
// puq_pkg: payload structs, config struct, pipeline constants and helper
// functions for the particle update block. No dependencies.
package puq_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // back-end stage map
  localparam int DIV_STG  = 8;            // 2 quotient bits per stage
  localparam int ST_LOAD  = 0;
  localparam int ST_MUL   = DIV_STG + 1;
  localparam int ST_SUM   = DIV_STG + 2;
  localparam int ST_HALF  = DIV_STG + 3;
  localparam int NSTG     = DIV_STG + 4;

  // config register indexes
  localparam logic [1:0] CFG_FRAME_STEP    = 2'd0;
  localparam logic [1:0] CFG_SPRITE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_SPRITE_HEIGHT = 2'd2;

  localparam logic [15:0] FRAME_STEP_RST = 16'd68;
  localparam logic [10:0] SPRITE_RST     = 11'd32;

  localparam logic signed [21:0] POS_HI = 22'sd524287;
  localparam logic signed [21:0] POS_LO = -22'sd524288;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [15:0]        age;
    logic [15:0]        lifetime;
    logic [31:0]        color_begin;
    logic [31:0]        color_finish;
    logic [15:0]        size_begin;
    logic [15:0]        size_finish;
  } puq_in_t;

  typedef struct packed {
    logic signed [19:0] new_pos_x;
    logic signed [19:0] new_pos_y;
    logic [15:0]        new_age;
    logic               expired;
    logic signed [19:0] quad_left;
    logic signed [19:0] quad_right;
    logic signed [19:0] quad_top;
    logic signed [19:0] quad_bottom;
    logic [31:0]        quad_color;
  } puq_out_t;

  typedef struct packed {
    logic [15:0] frame_step;
    logic [10:0] sprite_width;
    logic [10:0] sprite_height;
  } cfg_t;

  // front-end result, one queue entry
  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [31:0] mul_x;
    logic signed [31:0] mul_y;
    logic [15:0]        new_age;
    logic               expired;
    logic               r_one;
    logic [15:0]        age;
    logic [15:0]        lifetime;
    logic [31:0]        color_begin;
    logic [31:0]        color_finish;
    logic [15:0]        size_begin;
    logic [15:0]        size_finish;
  } fr_t;

  // back-end stage word
  typedef struct packed {
    logic signed [19:0]      nx;
    logic signed [19:0]      ny;
    logic [15:0]             nage;
    logic                    expired;
    logic                    r_one;
    logic [15:0]             life;
    logic [15:0]             rem;
    logic [15:0]             quo;
    logic [31:0]             cb;
    logic [31:0]             cf;
    logic [15:0]             sb;
    logic [15:0]             sf;
    logic signed [34:0]      prod_s;
    logic [3:0][26:0]        prod_c;
    logic [15:0]             size;
    logic [31:0]             col;
    logic [17:0]             hw;
    logic [17:0]             hh;
  } bk_t;

  function automatic logic signed [19:0] sat_pos(input logic signed [21:0] x);
    if (x > POS_HI) return POS_HI[19:0];
    if (x < POS_LO) return POS_LO[19:0];
    return x[19:0];
  endfunction

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [16:0] div_step(input logic [15:0] rem,
                                           input logic [15:0] life);
    logic [16:0] r2;
    logic [16:0] diff;
    r2   = {rem, 1'b0};
    diff = r2 - {1'b0, life};
    if (r2 >= {1'b0, life}) return {1'b1, diff[15:0]};
    return {1'b0, r2[15:0]};
  endfunction

endpackage

/* rtl/puq_front.sv */
// puq_front: accepts particles, classifies the life ratio, computes new
// age, expiry and the velocity products. Depends on puq_pkg.
module puq_front import puq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  puq_in_t in_data,
  output logic    q_valid,
  input  logic    q_ready,
  output fr_t     q_data
);

  fr_t  f_r, f_nxt;
  logic f_v_r;

  logic [16:0]        age_sum;
  logic signed [32:0] mx, my;

  assign in_ready = !f_v_r || q_ready;
  assign q_valid  = f_v_r;
  assign q_data   = f_r;

  always_comb begin
    age_sum = {1'b0, in_data.age} + {1'b0, cfg.frame_step};
    mx      = in_data.vel_x * $signed({1'b0, cfg.frame_step});
    my      = in_data.vel_y * $signed({1'b0, cfg.frame_step});

    f_nxt.pos_x        = in_data.pos_x;
    f_nxt.pos_y        = in_data.pos_y;
    f_nxt.mul_x        = mx[31:0];
    f_nxt.mul_y        = my[31:0];
    f_nxt.new_age      = age_sum[16] ? 16'hFFFF : age_sum[15:0];
    f_nxt.expired      = (f_nxt.new_age >= in_data.lifetime);
    f_nxt.r_one        = (in_data.lifetime == 16'd0) || (in_data.age >= in_data.lifetime);
    f_nxt.age          = in_data.age;
    f_nxt.lifetime     = in_data.lifetime;
    f_nxt.color_begin  = in_data.color_begin;
    f_nxt.color_finish = in_data.color_finish;
    f_nxt.size_begin   = in_data.size_begin;
    f_nxt.size_finish  = in_data.size_finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_v_r <= 1'b1;
    end else if (q_ready) begin
      f_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_r <= f_nxt;
    end
  end

endmodule

/* rtl/puq_queue.sv */
// puq_queue: short register FIFO between front and back ends.
// Depends on puq_pkg (fr_t, Q_DEPTH).
module puq_queue import puq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  fr_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output fr_t  out_data
);

  fr_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, rptr_r;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_ready  = (cnt_r != Q_CW'(Q_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= in_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH))
    else $error("queue count past depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != Q_CW'(Q_DEPTH) && cnt_r != '0) |-> (wptr_r != rptr_r))
    else $error("queue pointers collide while partly full");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

/* rtl/puq_back.sv */
// puq_back: stalling pipeline that divides age by lifetime, interpolates
// size and colour, scales the sprite and emits the quad. Depends on puq_pkg.
module puq_back import puq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  output logic     q_ready,
  input  fr_t      q_data,
  output logic     out_valid,
  input  logic     out_ready,
  output puq_out_t out_data
);

  bk_t        st_r   [NSTG];
  bk_t        st_nxt [NSTG];
  logic [NSTG-1:0] v_r;
  puq_out_t   out_r, out_nxt;
  logic       out_v_r;
  logic       adv;

  assign adv       = !out_v_r || out_ready;
  assign q_ready   = adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    bk_t                t;
    logic [16:0]        s0, s1;
    logic [16:0]        r16;
    logic signed [16:0] ds;
    logic signed [8:0]  dc;
    logic signed [18:0] sum_s;
    logic signed [10:0] sum_c;
    logic signed [26:0] pc;
    logic [26:0]        pw, ph;

    // load: position update and divider seed
    t       = '0;
    t.nx    = sat_pos(22'(q_data.pos_x) + 22'($signed(q_data.mul_x) >>> 12));
    t.ny    = sat_pos(22'(q_data.pos_y) + 22'($signed(q_data.mul_y) >>> 12));
    t.nage  = q_data.new_age;
    t.expired = q_data.expired;
    t.r_one = q_data.r_one;
    t.life  = q_data.lifetime;
    t.rem   = q_data.age;
    t.quo   = '0;
    t.cb    = q_data.color_begin;
    t.cf    = q_data.color_finish;
    t.sb    = q_data.size_begin;
    t.sf    = q_data.size_finish;
    st_nxt[ST_LOAD] = t;

    // divider, two quotient bits per stage
    for (int k = 1; k <= DIV_STG; k++) begin
      t     = st_r[k-1];
      s0    = div_step(t.rem, t.life);
      s1    = div_step(s0[15:0], t.life);
      t.rem = s1[15:0];
      t.quo = {t.quo[13:0], s0[16], s1[16]};
      st_nxt[k] = t;
    end

    // interpolation products
    t   = st_r[ST_MUL-1];
    r16 = t.r_one ? 17'h10000 : {1'b0, t.quo};
    ds  = $signed({1'b0, t.sf}) - $signed({1'b0, t.sb});
    t.prod_s = ds * $signed({1'b0, r16});
    for (int c = 0; c < 4; c++) begin
      dc = $signed({1'b0, t.cf[8*c +: 8]}) - $signed({1'b0, t.cb[8*c +: 8]});
      pc = dc * $signed({1'b0, r16});
      t.prod_c[c] = pc;
    end
    st_nxt[ST_MUL] = t;

    // interpolation sums
    t     = st_r[ST_SUM-1];
    sum_s = $signed({3'b0, t.sb}) + 19'(t.prod_s >>> 16);
    t.size = sum_s[15:0];
    for (int c = 0; c < 4; c++) begin
      sum_c = $signed({3'b0, t.cb[8*c +: 8]}) + 11'($signed(t.prod_c[c]) >>> 16);
      t.col[8*c +: 8] = sum_c[7:0];
    end
    st_nxt[ST_SUM] = t;

    // half sprite extents, Q.4 pixels
    t    = st_r[ST_HALF-1];
    pw   = {16'b0, cfg.sprite_width}  * {11'b0, t.size};
    ph   = {16'b0, cfg.sprite_height} * {11'b0, t.size};
    t.hw = pw[26:9];
    t.hh = ph[26:9];
    st_nxt[ST_HALF] = t;
  end

  always_comb begin
    bk_t t;
    t = st_r[NSTG-1];
    out_nxt.new_pos_x   = t.nx;
    out_nxt.new_pos_y   = t.ny;
    out_nxt.new_age     = t.nage;
    out_nxt.expired     = t.expired;
    out_nxt.quad_left   = sat_pos(22'(t.nx) - $signed({4'b0, t.hw}));
    out_nxt.quad_right  = sat_pos(22'(t.nx) + $signed({4'b0, t.hw}));
    out_nxt.quad_top    = sat_pos(22'(t.ny) - $signed({4'b0, t.hh}));
    out_nxt.quad_bottom = sat_pos(22'(t.ny) + $signed({4'b0, t.hh}));
    out_nxt.quad_color  = t.col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r     <= {v_r[NSTG-2:0], q_valid};
      out_v_r <= v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NSTG; k++) st_r[k] <= st_nxt[k];
      out_r <= out_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v_r) && $stable(out_v_r)))
    else $error("back pipeline moved while stalled");

endmodule

/* rtl/particle_update_quad_emit.sv */
// particle_update_quad_emit: top level, config registers, front end,
// queue and back end. Depends on puq_pkg, puq_front, puq_queue, puq_back.
// Throughput: one item per cycle while out_ready does not stall the back end, which is
// fully pipelined (8-stage radix-4 divider for age/lifetime, then 3 math stages).
// Reset: synchronous active-low rst_n clears all valid flags and queue
// pointers and loads frame_step=68, sprite_width=32, sprite_height=32.
module particle_update_quad_emit import puq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // particle input
  input  logic        in_valid,
  output logic        in_ready,
  input  puq_in_t     in_data,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output puq_out_t    out_data,
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // config registers; the user must write them only while the block is idle (the block
  // itself does not enforce this), so the pipeline reads them live without shadowing
  cfg_t cfg_r;

  // front -> queue -> back
  logic fq_valid, fq_ready;
  fr_t  fq_data;
  logic qb_valid, qb_ready;
  fr_t  qb_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_step    <= FRAME_STEP_RST;
      cfg_r.sprite_width  <= SPRITE_RST;
      cfg_r.sprite_height <= SPRITE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_STEP:    cfg_r.frame_step    <= cfg_data;
        CFG_SPRITE_WIDTH:  cfg_r.sprite_width  <= cfg_data[10:0];
        CFG_SPRITE_HEIGHT: cfg_r.sprite_height <= cfg_data[10:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front: ratio classification, new age, velocity x step products
  puq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  // short queue lets the front keep taking items while the back stalls
  puq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  // back: divide, interpolate, scale sprite, emit quad; its output
  // register holds a waiting result while the queue keeps filling
  puq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* test/particle_update_quad_emit_tb.sv */
// Self-checking testbench for particle_update_quad_emit: directed corner items,
// config sweeps, back-pressure and random traffic checked against a local predictor.
// Depends on puq_pkg and the particle_update_quad_emit RTL.
module particle_update_quad_emit_tb;
  import puq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;  // index with no register behind it
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 30;          // idle wait after the final drain, as margin
  localparam int IDLE_PCT = 21;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  puq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  puq_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [1:0]  cfg_index = CFG_FRAME_STEP;
  logic [15:0] cfg_data = '0;

  // Local copy of the config registers, mirrors the reset values.
  logic [15:0] step_q412 = FRAME_STEP_RST;
  logic [10:0] tex_w = SPRITE_RST;
  logic [10:0] tex_h = SPRITE_RST;

  puq_out_t pending_results[$];  // predicted results, oldest first
  puq_out_t want;
  int       mismatches = 0;
  int       cycle_cnt = 0;
  bit       idle_on = 1'b0;      // random idling on both sides
  int       hold_left = 0;       // receiver hold-off, counted down by the receiver

  particle_update_quad_emit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp to the signed 20-bit Q16.4 range.
  function automatic logic signed [19:0] clamp_pos(input longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  // Linear blend a..b by a Q1.16 ratio (65536 is one); floor on the step.
  function automatic longint blend(input longint a, input longint b, input longint ratio);
    return a + (((b - a) * ratio) >>> 16);
  endfunction

  function automatic puq_out_t predict_particle(input puq_in_t p);
    puq_out_t    r;
    longint      ratio;
    longint      nx;
    longint      ny;
    longint      sz;
    longint      hw;
    longint      hh;
    logic [16:0] age_sum;
    // Life ratio saturates to one once the particle is at or past its
    // lifetime, and for a zero lifetime.
    if (p.lifetime == 16'd0 || p.age >= p.lifetime)
      ratio = 65536;
    else
      ratio = (longint'(p.age) << 16) / longint'(p.lifetime);

    // Motion: velocity times Q4.12 step, floored, then saturated.
    nx = clamp_pos(longint'(p.pos_x) + ((longint'(p.vel_x) * longint'(step_q412)) >>> 12));
    ny = clamp_pos(longint'(p.pos_y) + ((longint'(p.vel_y) * longint'(step_q412)) >>> 12));

    // Half quad size in Q.4 pixels: texture size * Q4.12 scale / 2.
    sz = blend(longint'(p.size_begin), longint'(p.size_finish), ratio);
    hw = (longint'(tex_w) * sz) >> 9;
    hh = (longint'(tex_h) * sz) >> 9;

    for (int ch = 0; ch < 4; ch++) begin
      r.quad_color[8*ch +: 8] = 8'(blend(longint'(p.color_begin[8*ch +: 8]),
                                         longint'(p.color_finish[8*ch +: 8]), ratio));
    end

    age_sum     = p.age + step_q412;
    r.new_age   = age_sum[16] ? 16'hFFFF : age_sum[15:0];
    r.expired   = (r.new_age >= p.lifetime);
    r.new_pos_x = nx[19:0];
    r.new_pos_y = ny[19:0];
    r.quad_left   = clamp_pos(nx - hw);
    r.quad_right  = clamp_pos(nx + hw);
    r.quad_top    = clamp_pos(ny - hh);
    r.quad_bottom = clamp_pos(ny + hh);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every accepted result is matched against the oldest
  // prediction. Sampled at the rising edge, so pre-edge values are seen.
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("new_pos_x",   32'(want.new_pos_x),   32'(out_data.new_pos_x));
        check_field("new_pos_y",   32'(want.new_pos_y),   32'(out_data.new_pos_y));
        check_field("new_age",     32'(want.new_age),     32'(out_data.new_age));
        check_field("expired",     32'(want.expired),     32'(out_data.expired));
        check_field("quad_left",   32'(want.quad_left),   32'(out_data.quad_left));
        check_field("quad_right",  32'(want.quad_right),  32'(out_data.quad_right));
        check_field("quad_top",    32'(want.quad_top),    32'(out_data.quad_top));
        check_field("quad_bottom", 32'(want.quad_bottom), 32'(out_data.quad_bottom));
        check_field("quad_color",  want.quad_color,       out_data.quad_color);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off when a test asks for one.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one particle; valid stays up across back-to-back items and only
  // drops for random idle cycles or a drain. Prediction is taken at the accepting edge.
  task automatic send_particle(input puq_in_t p);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_particle(p));
  endtask

  // Stop offering and wait for every predicted result to come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_STEP:    step_q412 = val;
      CFG_SPRITE_WIDTH:  tex_w = val[10:0];
      CFG_SPRITE_HEIGHT: tex_h = val[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sprite writes carry random junk above bit 10 to check it is dropped.
  task automatic apply_setting(input logic [15:0] fs, input logic [10:0] w,
                               input logic [10:0] h);
    drain_results();
    write_reg(CFG_FRAME_STEP, fs);
    write_reg(CFG_SPRITE_WIDTH, {5'($urandom), w});
    write_reg(CFG_SPRITE_HEIGHT, {5'($urandom), h});
  endtask

  function automatic puq_in_t random_particle();
    puq_in_t p;
    int      mode;
    p.pos_x        = 20'($urandom);
    p.pos_y        = 20'($urandom);
    p.vel_x        = 16'($urandom);
    p.vel_y        = 16'($urandom);
    p.age          = 16'($urandom);
    p.lifetime     = 16'($urandom);
    p.color_begin  = $urandom;
    p.color_finish = $urandom;
    p.size_begin   = 16'($urandom);
    p.size_finish  = 16'($urandom);
    mode = $urandom_range(9);
    case (mode)
      0: ;                                 // raw random bits
      1: p.lifetime = 16'd0;
      2: p.age = p.lifetime + 16'($urandom_range(0, 65535 - p.lifetime));
      3: begin                             // near the position rails
        p.pos_x = $urandom_range(1) ? 20'sd524287 - 20'($urandom_range(4095))
                                    : -20'sd524288 + 20'($urandom_range(4095));
        p.pos_y = $urandom_range(1) ? 20'sd524287 - 20'($urandom_range(4095))
                                    : -20'sd524288 + 20'($urandom_range(4095));
      end
      default: begin                       // live particle, age below lifetime
        p.lifetime = 16'($urandom_range(1, 65535));
        p.age      = 16'($urandom_range(0, p.lifetime - 1));
        p.size_begin  = 16'($urandom_range(0, 16'h2000));
        p.size_finish = 16'($urandom_range(0, 16'h2000));
      end
    endcase
    return p;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_particle(random_particle());
  endtask

  // Rail cases that change meaning with each config setting.
  task automatic send_rail_particles();
    send_particle('{20'sd524287, 20'sd524287, 16'sd32767, 16'sd32767, 16'd0, 16'd1,
                    32'h0, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF});
    send_particle('{-20'sd524288, -20'sd524288, -16'sd32768, -16'sd32768, 16'd1, 16'd0,
                    32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'h0});
    send_particle('{20'sd0, 20'sd0, -16'sd1, 16'sd1, 16'hFFFF, 16'hFFFF,
                    32'h80808080, 32'h7F7F7F7F, 16'h1000, 16'h1000});
    send_particle('{-20'sd1, 20'sd1, 16'sd0, 16'sd0, 16'hFFF0, 16'd100,
                    32'h12345678, 32'h87654321, 16'd0, 16'hFFFF});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner items at the reset config.
  task automatic test_directed_corners();
    send_particle('0);
    // zero lifetime: end colour and size, expired
    send_particle('{20'sd160, -20'sd160, 16'sd16, -16'sd16, 16'd100, 16'd0,
                    32'h00000000, 32'hFFFFFFFF, 16'h0000, 16'hFFFF});
    // age past lifetime, and age equal to lifetime
    send_particle('{20'sd0, 20'sd0, 16'sd100, 16'sd100, 16'd5000, 16'd4096,
                    32'hFF00FF00, 32'h00FF00FF, 16'h1000, 16'h3000});
    send_particle('{20'sd0, 20'sd0, 16'sd100, 16'sd100, 16'd4096, 16'd4096,
                    32'hFF00FF00, 32'h00FF00FF, 16'h1000, 16'h3000});
    // age overflow saturates new age
    send_particle('{20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'hFFFF, 16'hFFFF,
                    32'h0, 32'h0, 16'h1000, 16'h1000});
    send_particle('{20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'd65500, 16'd65535,
                    32'h01020304, 32'hFEFDFCFB, 16'h1000, 16'h2000});
    // half-way ratio and a tiny ratio with falling colours (floor on negatives)
    send_particle('{20'sd1000, 20'sd2000, 16'sd50, -16'sd50, 16'd2048, 16'd4096,
                    32'hFF00FF00, 32'h00FF00FF, 16'h1000, 16'h3000});
    send_particle('{20'sd1000, 20'sd2000, -16'sd1, -16'sd3, 16'd1, 16'd65535,
                    32'hFFFFFFFF, 32'h00000000, 16'hFFFF, 16'h0000});
    // position saturation both ways at full velocity
    send_particle('{20'sd524287, -20'sd524288, 16'sd32767, -16'sd32768, 16'd0, 16'd4096,
                    32'h0, 32'h0, 16'h1000, 16'h1000});
    // edge saturation with the largest size
    send_particle('{20'sd524000, -20'sd524000, 16'sd0, 16'sd0, 16'd0, 16'd4096,
                    32'h0, 32'h0, 16'hFFFF, 16'hFFFF});
    send_particle('{-20'sd524000, 20'sd524000, 16'sd0, 16'sd0, 16'd0, 16'd4096,
                    32'h0, 32'h0, 16'hFFFF, 16'hFFFF});
    // all ones
    send_particle('{-20'sd1, -20'sd1, -16'sd1, -16'sd1, 16'hFFFF, 16'hFFFF,
                    32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF});
    send_rail_particles();
  endtask

  // Several config settings, extremes included, each with rail and random items.
  task automatic test_config_sweep();
    // zero step and zero sprite: no motion, degenerate quad
    apply_setting(16'd0, 11'd0, 11'd0);
    send_rail_particles();
    send_random(70);
    apply_setting(16'hFFFF, 11'd2047, 11'd2047);
    send_rail_particles();
    send_random(70);
    apply_setting(16'd1, 11'd1, 11'd1);
    send_rail_particles();
    send_random(70);
    apply_setting(16'd4096, 11'd1024, 11'd1024);
    send_rail_particles();
    send_random(70);
    // the spare index must not disturb any register
    drain_results();
    write_reg(CFG_UNUSED, 16'($urandom));
    send_random(40);
    apply_setting(16'($urandom), 11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
    send_rail_particles();
    send_random(70);
  endtask

  // Receiver holds off while the sender keeps pushing: the block must fill
  // up, drop in_ready, and lose nothing.
  task automatic test_backpressure();
    drain_results();
    idle_on = 1'b0;
    @(negedge clk);
    hold_left = 120;
    send_random(60);
    idle_on = 1'b1;
  endtask

  // Long random run: a first stretch at full rate, then random idling.
  task automatic test_random_traffic();
    apply_setting(16'd68, 11'd32, 11'd48);
    idle_on = 1'b0;
    send_random(150);
    idle_on = 1'b1;
    send_random(180);
  endtask

  initial begin
    // Reset held from time zero, then released at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_on = 1'b1;
    test_directed_corners();
    test_config_sweep();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
